@@ hdl/skvt_pkg.sv @@
// Shared types and codes for the sorted key/value table.
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

  localparam int MODE_BITS = 3;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_OUT_BITS = 7;

  localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_INSERT = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_ERASE = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_READ_OR_ZERO = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR = 3'd4;

  localparam logic [STATUS_BITS-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_ABSENT = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_PRESENT = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd3;

  typedef enum logic [1:0] {
    CELL_KEEP,
    CELL_INSERT,
    CELL_ERASE,
    CELL_CLEAR
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      cmp_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/skvt_cell.sv @@
// One table slot: holds an entry, compares it with the request key and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module skvt_cell #(
  parameter int KEY_BITS = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire skvt_pkg::cell_ctl_t     ctl,
  input  wire logic [KEY_BITS-1:0]     cmp_key,
  input  wire logic [VALUE_BITS-1:0]   new_age,
  input  wire logic [VALUE_BITS-1:0]   new_weight,
  input  wire logic [KEY_BITS-1:0]     prev_key,
  input  wire logic [VALUE_BITS-1:0]   prev_age,
  input  wire logic [VALUE_BITS-1:0]   prev_weight,
  input  wire logic                    prev_valid,
  input  wire logic                    prev_ge,
  input  wire logic [KEY_BITS-1:0]     next_key,
  input  wire logic [VALUE_BITS-1:0]   next_age,
  input  wire logic [VALUE_BITS-1:0]   next_weight,
  input  wire logic                    next_valid,
  output logic [KEY_BITS-1:0]          key,
  output logic [VALUE_BITS-1:0]        age,
  output logic [VALUE_BITS-1:0]        weight,
  output logic                         valid,
  output logic                         ge,
  output logic                         hit
);

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] age_r, age_nxt;
  logic [VALUE_BITS-1:0] weight_r, weight_nxt;
  logic                  valid_r, valid_nxt;
  logic                  lt_r, eq_r;
  logic                  load;

  always_comb begin
    key_nxt = key_r;
    age_nxt = age_r;
    weight_nxt = weight_r;
    valid_nxt = valid_r;
    load = 1'b0;
    case (ctl.cmd)
      skvt_pkg::CELL_INSERT: begin
        if (!lt_r) begin
          load = 1'b1;
          if (!prev_ge) begin
            key_nxt = cmp_key;
            age_nxt = new_age;
            weight_nxt = new_weight;
            valid_nxt = 1'b1;
          end else begin
            key_nxt = prev_key;
            age_nxt = prev_age;
            weight_nxt = prev_weight;
            valid_nxt = prev_valid;
          end
        end
      end
      skvt_pkg::CELL_ERASE: begin
        if (!lt_r) begin
          load = 1'b1;
          key_nxt = next_key;
          age_nxt = next_age;
          weight_nxt = next_weight;
          valid_nxt = next_valid;
        end
      end
      skvt_pkg::CELL_CLEAR: valid_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.cmp_en) begin
        lt_r <= valid_r && (key_r < cmp_key);
        eq_r <= valid_r && (key_r == cmp_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= key_nxt;
      age_r <= age_nxt;
      weight_r <= weight_nxt;
    end
  end

  assign key = key_r;
  assign age = age_r;
  assign weight = weight_r;
  assign valid = valid_r;
  assign ge = !lt_r;
  assign hit = eq_r;

endmodule

`default_nettype wire

@@ hdl/sorted_key_value_table.sv @@
// Top level of the sorted key/value table built as a chain of entry cells.
//
// Requests enter on the in_ channel (in_valid, in_stall) and name an operation:
// lookup, insert, erase, read or insert zero, or clear. Every request gives one
// result on the out_ channel (out_valid, out_stall) with a status, the entry's
// age and weight, and the entry count after the operation.
// At the accepting edge every cell compares its key with the request key. At
// the edge that finishes it, which a stalled result can delay, the top level
// reduces the cell flags, decides the operation, writes the result register
// and makes every cell keep, load its neighbor's entry, load the new entry or
// drop its entry on clear, all in one step. A new request is taken at the edge
// after the previous one finishes, so the block cannot take a new request
// before the previous one is done.
// The result register lets a new request be accepted while a result waits.
// If the receiver stalls, the result holds and the next request waits in the
// request register until the result register frees up.
// Reset empties the table and clears both channels; stored entries keep no
// meaning until they are written again.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_value_table #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          in_valid,
  output logic                                         in_stall,
  input  wire logic [skvt_pkg::MODE_BITS-1:0]          in_mode,
  input  wire logic [KEY_BITS-1:0]                     in_key,
  input  wire logic [VALUE_BITS-1:0]                   in_age_in,
  input  wire logic [VALUE_BITS-1:0]                   in_weight_in,
  output logic                                         out_valid,
  input  wire                                          out_stall,
  output logic [skvt_pkg::STATUS_BITS-1:0]             out_status,
  output logic [VALUE_BITS-1:0]                        out_age_out,
  output logic [VALUE_BITS-1:0]                        out_weight_out,
  output logic [skvt_pkg::COUNT_OUT_BITS-1:0]          out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                              busy_r;
  logic [skvt_pkg::MODE_BITS-1:0]    mode_r;
  logic [KEY_BITS-1:0]               key_r;
  logic [VALUE_BITS-1:0]             age_r, weight_r;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic                              out_valid_r;
  logic [skvt_pkg::STATUS_BITS-1:0]  status_r, status_nxt;
  logic [VALUE_BITS-1:0]             age_out_r, age_out_nxt;
  logic [VALUE_BITS-1:0]             weight_out_r, weight_out_nxt;
  logic [skvt_pkg::COUNT_OUT_BITS-1:0] count_out_r;

  logic                              accept, fire;
  logic                              found, full;
  logic [VALUE_BITS-1:0]             hit_age, hit_weight;
  logic [VALUE_BITS-1:0]             new_age, new_weight;
  skvt_pkg::cell_cmd_t               cmd;
  skvt_pkg::cell_ctl_t               ctl;

  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [VALUE_BITS-1:0] cell_age [CAPACITY];
  logic [VALUE_BITS-1:0] cell_weight [CAPACITY];
  logic [CAPACITY-1:0]   cell_valid, cell_ge, cell_hit;

  assign accept = in_valid && !busy_r;
  assign fire = busy_r && (!out_valid_r || !out_stall);
  assign in_stall = busy_r;
  assign full = (cnt_r == CNT_W'(CAPACITY));
  assign found = |cell_hit;

  always_comb begin
    hit_age = '0;
    hit_weight = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_age = hit_age | (cell_hit[i] ? cell_age[i] : '0);
      hit_weight = hit_weight | (cell_hit[i] ? cell_weight[i] : '0);
    end
  end

  always_comb begin
    cmd = skvt_pkg::CELL_KEEP;
    cnt_nxt = cnt_r;
    status_nxt = skvt_pkg::STATUS_DONE;
    age_out_nxt = '0;
    weight_out_nxt = '0;
    new_age = age_r;
    new_weight = weight_r;
    case (mode_r)
      skvt_pkg::MODE_LOOKUP: begin
        if (found) begin
          age_out_nxt = hit_age;
          weight_out_nxt = hit_weight;
        end else begin
          status_nxt = skvt_pkg::STATUS_ABSENT;
        end
      end
      skvt_pkg::MODE_READ_OR_ZERO: begin
        new_age = '0;
        new_weight = '0;
        if (found) begin
          age_out_nxt = hit_age;
          weight_out_nxt = hit_weight;
        end else if (full) begin
          status_nxt = skvt_pkg::STATUS_FULL;
        end else begin
          cmd = skvt_pkg::CELL_INSERT;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      skvt_pkg::MODE_INSERT: begin
        if (found) begin
          status_nxt = skvt_pkg::STATUS_PRESENT;
          age_out_nxt = hit_age;
          weight_out_nxt = hit_weight;
        end else if (full) begin
          status_nxt = skvt_pkg::STATUS_FULL;
        end else begin
          cmd = skvt_pkg::CELL_INSERT;
          cnt_nxt = cnt_r + CNT_W'(1);
          age_out_nxt = age_r;
          weight_out_nxt = weight_r;
        end
      end
      skvt_pkg::MODE_ERASE: begin
        if (found) begin
          cmd = skvt_pkg::CELL_ERASE;
          cnt_nxt = cnt_r - CNT_W'(1);
          age_out_nxt = hit_age;
          weight_out_nxt = hit_weight;
        end else begin
          status_nxt = skvt_pkg::STATUS_ABSENT;
        end
      end
      skvt_pkg::MODE_CLEAR: begin
        cmd = skvt_pkg::CELL_CLEAR;
        cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    ctl.cmp_en = accept;
    ctl.cmd = fire ? cmd : skvt_pkg::CELL_KEEP;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0]   p_key, n_key;
    logic [VALUE_BITS-1:0] p_age, p_weight, n_age, n_weight;
    logic                  p_valid, p_ge, n_valid;

    if (i == 0) begin : g_first
      assign p_key = '0;
      assign p_age = '0;
      assign p_weight = '0;
      assign p_valid = 1'b1;
      assign p_ge = 1'b0;
    end else begin : g_mid
      assign p_key = cell_key[i-1];
      assign p_age = cell_age[i-1];
      assign p_weight = cell_weight[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_ge = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign n_key = '0;
      assign n_age = '0;
      assign n_weight = '0;
      assign n_valid = 1'b0;
    end else begin : g_inner
      assign n_key = cell_key[i+1];
      assign n_age = cell_age[i+1];
      assign n_weight = cell_weight[i+1];
      assign n_valid = cell_valid[i+1];
    end

    skvt_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cmp_key    (accept ? in_key : key_r),
      .new_age    (new_age),
      .new_weight (new_weight),
      .prev_key   (p_key),
      .prev_age   (p_age),
      .prev_weight(p_weight),
      .prev_valid (p_valid),
      .prev_ge    (p_ge),
      .next_key   (n_key),
      .next_age   (n_age),
      .next_weight(n_weight),
      .next_valid (n_valid),
      .key        (cell_key[i]),
      .age        (cell_age[i]),
      .weight     (cell_weight[i]),
      .valid      (cell_valid[i]),
      .ge         (cell_ge[i]),
      .hit        (cell_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end
      if (fire) begin
        cnt_r <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      key_r <= in_key;
      age_r <= in_age_in;
      weight_r <= in_weight_in;
    end
    if (fire) begin
      status_r <= status_nxt;
      age_out_r <= age_out_nxt;
      weight_out_r <= weight_out_nxt;
      count_out_r <= skvt_pkg::COUNT_OUT_BITS'(cnt_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_age_out = age_out_r;
  assign out_weight_out = weight_out_r;
  assign out_entry_count = count_out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(cnt_r))
    else $error("occupied cells disagree with entry count");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot0(cell_hit))
    else $error("more than one cell matches the request key");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && !busy_r)
    else $error("finished request did not produce a result");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the sorted key/value table, with directed and random requests.
`timescale 1ns / 1ps

module testbench;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int VALUE_BITS = 32;
  localparam int MODE_BITS = skvt_pkg::MODE_BITS;
  localparam int STATUS_BITS = skvt_pkg::STATUS_BITS;
  localparam int COUNT_OUT_BITS = skvt_pkg::COUNT_OUT_BITS;
  localparam logic [MODE_BITS-1:0] MODE_TOP = MODE_BITS'((1 << MODE_BITS) - 1);
  localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
  localparam int RANDOM_ITEMS = 1120;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [STATUS_BITS-1:0]    status;
    logic [VALUE_BITS-1:0]     age;
    logic [VALUE_BITS-1:0]     weight;
    logic [COUNT_OUT_BITS-1:0] count;
  } table_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [MODE_BITS-1:0]      in_mode;
  logic [KEY_BITS-1:0]       in_key;
  logic [VALUE_BITS-1:0]     in_age_in;
  logic [VALUE_BITS-1:0]     in_weight_in;
  logic                      out_valid;
  logic                      out_stall;
  logic [STATUS_BITS-1:0]    out_status;
  logic [VALUE_BITS-1:0]     out_age_out;
  logic [VALUE_BITS-1:0]     out_weight_out;
  logic [COUNT_OUT_BITS-1:0] out_entry_count;

  logic [KEY_BITS-1:0]   table_keys [CAPACITY];
  logic [VALUE_BITS-1:0] table_ages [CAPACITY];
  logic [VALUE_BITS-1:0] table_weights [CAPACITY];
  int                    table_count;

  table_result_t pending_results [$];
  int            mismatches;
  logic          hold_trigger;
  int            burst_left;

  sorted_key_value_table #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_key(in_key),
    .in_age_in(in_age_in),
    .in_weight_in(in_weight_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_age_out(out_age_out),
    .out_weight_out(out_weight_out),
    .out_entry_count(out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void table_place(int pos, logic [KEY_BITS-1:0] key,
                                      logic [VALUE_BITS-1:0] age,
                                      logic [VALUE_BITS-1:0] weight);
    for (int i = table_count; i > pos; i--) begin
      table_keys[i] = table_keys[i-1];
      table_ages[i] = table_ages[i-1];
      table_weights[i] = table_weights[i-1];
    end
    table_keys[pos] = key;
    table_ages[pos] = age;
    table_weights[pos] = weight;
    table_count++;
  endfunction

  function automatic table_result_t table_apply(logic [MODE_BITS-1:0] mode,
                                                logic [KEY_BITS-1:0] key,
                                                logic [VALUE_BITS-1:0] age,
                                                logic [VALUE_BITS-1:0] weight);
    table_result_t res;
    int            pos;
    logic          found;
    logic          full;
    res = '0;
    res.status = skvt_pkg::STATUS_DONE;
    pos = table_count;
    for (int i = table_count - 1; i >= 0; i--)
      if (table_keys[i] >= key) pos = i;
    found = (pos < table_count) && (table_keys[pos] == key);
    full = table_count >= CAPACITY;
    case (mode)
      skvt_pkg::MODE_LOOKUP, skvt_pkg::MODE_READ_OR_ZERO: begin
        if (found) begin
          res.age = table_ages[pos];
          res.weight = table_weights[pos];
        end else if (mode == skvt_pkg::MODE_LOOKUP) begin
          res.status = skvt_pkg::STATUS_ABSENT;
        end else if (full) begin
          res.status = skvt_pkg::STATUS_FULL;
        end else begin
          table_place(pos, key, '0, '0);
        end
      end
      skvt_pkg::MODE_INSERT: begin
        if (found) begin
          res.status = skvt_pkg::STATUS_PRESENT;
          res.age = table_ages[pos];
          res.weight = table_weights[pos];
        end else if (full) begin
          res.status = skvt_pkg::STATUS_FULL;
        end else begin
          table_place(pos, key, age, weight);
          res.age = age;
          res.weight = weight;
        end
      end
      skvt_pkg::MODE_ERASE: begin
        if (found) begin
          res.age = table_ages[pos];
          res.weight = table_weights[pos];
          for (int i = pos; i + 1 < table_count; i++) begin
            table_keys[i] = table_keys[i+1];
            table_ages[i] = table_ages[i+1];
            table_weights[i] = table_weights[i+1];
          end
          table_count--;
        end else begin
          res.status = skvt_pkg::STATUS_ABSENT;
        end
      end
      skvt_pkg::MODE_CLEAR: table_count = 0;
      default: ;
    endcase
    res.count = COUNT_OUT_BITS'(table_count);
    return res;
  endfunction

  task automatic send_request(logic [MODE_BITS-1:0] mode, logic [KEY_BITS-1:0] key,
                              logic [VALUE_BITS-1:0] age, logic [VALUE_BITS-1:0] weight);
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_key <= key;
    in_age_in <= age;
    in_weight_in <= weight;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(table_apply(mode, key, age, weight));
  endtask

  task automatic idle_input(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_input($urandom_range(6, 1));
      burst_left = ($urandom_range(7) == 0) ? 60 : $urandom_range(20, 1);
    end
  endtask

  task automatic wait_drained();
    idle_input(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: status %0d age %h weight %h count %0d",
                   out_status, out_age_out, out_weight_out, out_entry_count);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_age_out !== want.age ||
            out_weight_out !== want.weight || out_entry_count !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch: expected status %0d age %h weight %h count %0d, %s %0d %h %h %0d",
                     want.status, want.age, want.weight, want.count, "got",
                     out_status, out_age_out, out_weight_out, out_entry_count);
        end
      end
    end
  end

  initial begin
    int   cycle;
    int   style;
    int   hold_left;
    logic hold_seen;
    cycle = 0;
    style = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      cycle++;
      if (cycle % 64 == 0) style = $urandom_range(3);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(3) == 0);
          2: out_stall <= ($urandom_range(9) < 7);
          default: out_stall <= (cycle % 3 == 0);
        endcase
      end
    end
  end

  task automatic test_directed();
    send_request(skvt_pkg::MODE_LOOKUP, 32'd5, 32'h1234_5678, 32'h9abc_def0);
    send_request(skvt_pkg::MODE_ERASE, 32'd5, '0, '0);
    send_request(skvt_pkg::MODE_READ_OR_ZERO, 32'd7, VALUE_MAX, VALUE_MAX);
    send_request(skvt_pkg::MODE_INSERT, '0, VALUE_MAX, '0);
    send_request(skvt_pkg::MODE_INSERT, KEY_MAX, '0, VALUE_MAX);
    send_request(skvt_pkg::MODE_INSERT, 32'd7, 32'h1111_1111, 32'h2222_2222);
    send_request(skvt_pkg::MODE_LOOKUP, '0, '0, '0);
    send_request(skvt_pkg::MODE_LOOKUP, KEY_MAX, VALUE_MAX, VALUE_MAX);
    send_request(skvt_pkg::MODE_READ_OR_ZERO, '0, 32'h5555_5555, 32'haaaa_aaaa);
    send_request(skvt_pkg::MODE_INSERT, 32'h8000_0000, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    send_request(skvt_pkg::MODE_LOOKUP, 32'h7fff_ffff, '0, '0);
    send_request(skvt_pkg::MODE_LOOKUP, 32'h8000_0000, '0, '0);
    send_request(skvt_pkg::MODE_ERASE, 32'h8000_0000, '0, '0);
    send_request(skvt_pkg::MODE_ERASE, 32'h8000_0000, '0, '0);
    send_request(skvt_pkg::MODE_ERASE, KEY_MAX, '0, '0);
    for (int m = int'(skvt_pkg::MODE_CLEAR) + 1; m <= int'(MODE_TOP); m++)
      send_request(MODE_BITS'(m), $urandom, $urandom, $urandom);
    send_request(skvt_pkg::MODE_LOOKUP, '0, '0, '0);
    send_request(skvt_pkg::MODE_CLEAR, '0, VALUE_MAX, VALUE_MAX);
    send_request(skvt_pkg::MODE_LOOKUP, '0, '0, '0);
    send_request(skvt_pkg::MODE_CLEAR, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_full_table();
    logic [KEY_BITS-1:0] base;
    base = $urandom & 32'h7fff_ff00;
    for (int i = CAPACITY - 1; i >= 0; i--)
      send_request(skvt_pkg::MODE_INSERT, base + 32'(i * 4), $urandom, $urandom);
    send_request(skvt_pkg::MODE_INSERT, base + 32'd1, $urandom, $urandom);
    send_request(skvt_pkg::MODE_READ_OR_ZERO, KEY_MAX, '0, '0);
    send_request(skvt_pkg::MODE_READ_OR_ZERO, base + 32'd8, '0, '0);
    send_request(skvt_pkg::MODE_INSERT, base, $urandom, $urandom);
    send_request(skvt_pkg::MODE_LOOKUP, base + 32'(4 * (CAPACITY - 1)), '0, '0);
    send_request(skvt_pkg::MODE_ERASE, base + 32'd40, '0, '0);
    send_request(skvt_pkg::MODE_INSERT, KEY_MAX, VALUE_MAX, VALUE_MAX);
    send_request(skvt_pkg::MODE_INSERT, '0, '0, '0);
    send_request(skvt_pkg::MODE_ERASE, base, '0, '0);
    send_request(skvt_pkg::MODE_INSERT, '0, VALUE_MAX, '0);
    send_request(skvt_pkg::MODE_ERASE, KEY_MAX, '0, '0);
    send_request(skvt_pkg::MODE_READ_OR_ZERO, 32'hffff_fffe, '0, '0);
    send_request(skvt_pkg::MODE_LOOKUP, 32'hffff_fffe, '0, '0);
    send_request(skvt_pkg::MODE_CLEAR, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_trigger = ~hold_trigger;
    for (int i = 0; i < 30; i++)
      send_request(($urandom_range(1) == 0) ? skvt_pkg::MODE_INSERT : skvt_pkg::MODE_LOOKUP,
                   $urandom_range(40), $urandom, $urandom);
    wait_drained();
  endtask

  task automatic test_random();
    logic [KEY_BITS-1:0]   key_pool [100];
    logic [MODE_BITS-1:0]  mode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] age;
    logic [VALUE_BITS-1:0] weight;
    int                    profile;
    int                    pick;
    int                    insert_share;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 32'h8000_0000;
    profile = 0;
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 125 == 0) profile = $urandom_range(2);
      insert_share = (profile == 0) ? 60 : (profile == 1) ? 20 : 35;
      pick = $urandom_range(999);
      if (pick < 6) mode = skvt_pkg::MODE_CLEAR;
      else if (pick < 26)
        mode = MODE_BITS'($urandom_range(MODE_TOP, skvt_pkg::MODE_CLEAR + 1));
      else begin
        pick = $urandom_range(99);
        if (pick < insert_share) mode = skvt_pkg::MODE_INSERT;
        else if (pick < insert_share + 15) mode = skvt_pkg::MODE_LOOKUP;
        else if (pick < insert_share + 25) mode = skvt_pkg::MODE_READ_OR_ZERO;
        else mode = skvt_pkg::MODE_ERASE;
      end
      pick = $urandom_range(99);
      if (pick < 10) key = $urandom;
      else if (pick < 55 && table_count > 0) key = table_keys[$urandom_range(table_count - 1)];
      else key = key_pool[$urandom_range(99)];
      pick = $urandom_range(9);
      age = (pick == 0) ? '0 : (pick == 1) ? VALUE_MAX : $urandom;
      pick = $urandom_range(9);
      weight = (pick == 0) ? '0 : (pick == 1) ? VALUE_MAX : $urandom;
      send_request(mode, key, age, weight);
      pace_sender();
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = skvt_pkg::MODE_LOOKUP;
    in_key = '0;
    in_age_in = '0;
    in_weight_in = '0;
    hold_trigger = 1'b0;
    mismatches = 0;
    table_count = 0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_table();
    test_backpressure();
    test_random();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
